// ----- hw/rtl/ecf_pkg.sv -----
// Package for the eased colour crossfade: widths, constants and shared types.
// Used by the interfaces, the divider pipeline and the top level.
package ecf_pkg;

   localparam int ColorW   = 24;
   localparam int ElapsedW = 27;
   localparam int DurMsW   = 16;
   localparam int DurUsW   = 26;
   localparam int QuotW    = 17;
   localparam int ProgW    = 16;
   localparam int MsToUs   = 1000;
   localparam int DivSteps = QuotW;

   // Side data that travels beside each word through the pipeline
   typedef struct packed {
      logic [ColorW-1:0] old_color;
      logic [ColorW-1:0] new_color;
      logic              fin;
      logic              byp;
   } tag_type;

endpackage

// ----- hw/rtl/ecf_if.sv -----
// Channel interfaces for the eased colour crossfade: pixel in, pixel out, duration write.
// Depends on ecf_pkg.
interface ecf_req_if import ecf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ColorW-1:0]   old_color;
   logic [ColorW-1:0]   new_color;
   logic [ElapsedW-1:0] elapsed_us;
   logic                active;
   modport source (output valid, old_color, new_color, elapsed_us, active, input ready);
   modport sink   (input valid, old_color, new_color, elapsed_us, active, output ready);
endinterface

interface ecf_rsp_if import ecf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ColorW-1:0] out_color;
   logic              finished;
   modport source (output valid, out_color, finished, input ready);
   modport sink   (input valid, out_color, finished, output ready);
endinterface

interface ecf_csr_if import ecf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DurMsW-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/ecf_div.sv -----
// Restoring divider pipeline: one quotient bit per stage.
// Depends on ecf_pkg.
module ecf_div import ecf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [ElapsedW-1:0] in_num,
   input  logic [DurUsW-1:0]   dur,
   input  tag_type             in_tag,
   output logic                out_vld,
   output logic [QuotW-1:0]    out_quot,
   output tag_type             out_tag
);

   logic [ElapsedW-1:0] rem_ff  [DivSteps];
   logic [QuotW-1:0]    quot_ff [DivSteps];
   tag_type             tag_ff  [DivSteps];
   logic                vld_ff  [DivSteps];

   logic [ElapsedW-1:0] trial_in [DivSteps];
   logic [ElapsedW-1:0] rem_in   [DivSteps];
   logic [QuotW-1:0]    quot_in  [DivSteps];
   logic                bit_in   [DivSteps];

   // Shift in one dividend bit (zero) a stage, compare and subtract
   always_comb begin
      trial_in[0] = in_num;
      for (int k = 1; k < DivSteps; k++) begin
         trial_in[k] = {rem_ff[k-1][ElapsedW-2:0], 1'b0};
      end
      for (int k = 0; k < DivSteps; k++) begin
         bit_in[k] = trial_in[k] >= ElapsedW'(dur);
         rem_in[k] = bit_in[k] ? trial_in[k] - ElapsedW'(dur) : trial_in[k];
      end
      quot_in[0] = {{(QuotW-1){1'b0}}, bit_in[0]};
      for (int k = 1; k < DivSteps; k++) begin
         quot_in[k] = {quot_ff[k-1][QuotW-2:0], bit_in[k]};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivSteps; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < DivSteps; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int k = 0; k < DivSteps; k++) begin
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= quot_in[k];
         end
         for (int k = 1; k < DivSteps; k++) tag_ff[k] <= tag_ff[k-1];
      end
   end

   assign out_vld  = vld_ff[DivSteps-1];
   assign out_quot = quot_ff[DivSteps-1];
   assign out_tag  = tag_ff[DivSteps-1];

endmodule

// ----- hw/rtl/eased_color_crossfade.sv -----
// Eased colour crossfade: progress divide, cubic ease-in-out, per-channel blend.
// One word a cycle sustained while the result side takes each result.
// Stages: input, a 17-stage restoring divider, then the ease and blend stages.
// A stall on the result side holds the whole pipeline; nothing is dropped.
// Synchronous reset clears every valid bit and sets the duration to zero.
module eased_color_crossfade import ecf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ecf_req_if.sink    req_if,
   ecf_rsp_if.source  rsp_if,
   ecf_csr_if.sink    csr_if
);

   logic en;

   logic [DurUsW-1:0] dur_ff;

   logic                s1_vld_ff;
   logic [ElapsedW-1:0] s1_el_ff;
   tag_type             s1_tag_ff;
   tag_type             s1_tag_in;

   logic             dv_vld;
   logic [QuotW-1:0] dv_quot;
   tag_type          dv_tag;

   logic             sb_vld_ff, sc_vld_ff, sd_vld_ff, se_vld_ff, sf_vld_ff;
   tag_type          sb_tag_ff, sc_tag_ff, sd_tag_ff, se_tag_ff;
   logic             sb_hi_ff, sc_hi_ff, sd_hi_ff;
   logic [ProgW-1:0] sb_u_ff, sc_u_ff;
   logic [ProgW-1:0] p_in;
   logic [ProgW-1:0] u_in;
   logic [31:0]      sc_sq_ff;
   logic [47:0]      sd_cube_ff;
   logic [ProgW-1:0] c_in;
   logic [QuotW-1:0] inv_in;
   logic [ProgW-1:0] e_in;
   logic [ProgW-1:0] se_e_ff;
   logic [ColorW-1:0] mix_in;
   logic [ColorW-1:0] out_color_ff;
   logic              finished_ff;

   assign en           = ~sf_vld_ff | rsp_if.ready;
   assign req_if.ready = en;
   assign csr_if.ready = 1'b1;

   // Hold the duration in microseconds
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff <= '0;
      end else if (csr_if.valid) begin
         dur_ff <= DurUsW'(csr_if.data) * DurUsW'(MsToUs);
      end
   end

   // Input stage: classify the word
   always_comb begin
      s1_tag_in.old_color = req_if.old_color;
      s1_tag_in.new_color = req_if.new_color;
      s1_tag_in.fin       = req_if.active & (req_if.elapsed_us > ElapsedW'(dur_ff));
      s1_tag_in.byp       = ~req_if.active | s1_tag_in.fin | (dur_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_el_ff  <= req_if.elapsed_us;
         s1_tag_ff <= s1_tag_in;
      end
   end

   ecf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s1_vld_ff),
      .in_num   (s1_el_ff),
      .dur      (dur_ff),
      .in_tag   (s1_tag_ff),
      .out_vld  (dv_vld),
      .out_quot (dv_quot),
      .out_tag  (dv_tag)
   );

   // Saturate progress and fold it about one half
   always_comb begin
      p_in = dv_quot[QuotW-1] ? {ProgW{1'b1}} : dv_quot[ProgW-1:0];
      u_in = p_in[ProgW-1] ? ProgW'(QuotW'(1 << ProgW) - QuotW'(p_in)) : p_in;
   end

   // Cube, then round and unfold
   always_comb begin
      c_in   = ProgW'((sd_cube_ff + 48'(1 << 29)) >> 30);
      inv_in = QuotW'(1 << ProgW) - QuotW'(c_in);
      if (sd_hi_ff) begin
         e_in = inv_in[QuotW-1] ? {ProgW{1'b1}} : inv_in[ProgW-1:0];
      end else begin
         e_in = c_in;
      end
   end

   // Blend each channel with rounding half up
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic [25:0] acc;
         acc = 26'(se_tag_ff.old_color[ch*8 +: 8]) * 26'(QuotW'(1 << ProgW) - QuotW'(se_e_ff))
             + 26'(se_tag_ff.new_color[ch*8 +: 8]) * 26'(se_e_ff)
             + 26'(1 << 15);
         mix_in[ch*8 +: 8] = acc[23:16];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_vld_ff <= 1'b0;
         sc_vld_ff <= 1'b0;
         sd_vld_ff <= 1'b0;
         se_vld_ff <= 1'b0;
         sf_vld_ff <= 1'b0;
      end else if (en) begin
         sb_vld_ff <= dv_vld;
         sc_vld_ff <= sb_vld_ff;
         sd_vld_ff <= sc_vld_ff;
         se_vld_ff <= sd_vld_ff;
         sf_vld_ff <= se_vld_ff;
      end
   end

   // Advance payload through ease and blend
   always_ff @(posedge clock) begin
      if (en) begin
         sb_tag_ff    <= dv_tag;
         sb_hi_ff     <= p_in[ProgW-1];
         sb_u_ff      <= u_in;
         sc_tag_ff    <= sb_tag_ff;
         sc_hi_ff     <= sb_hi_ff;
         sc_u_ff      <= sb_u_ff;
         sc_sq_ff     <= 32'(sb_u_ff) * 32'(sb_u_ff);
         sd_tag_ff    <= sc_tag_ff;
         sd_hi_ff     <= sc_hi_ff;
         sd_cube_ff   <= 48'(sc_sq_ff) * 48'(sc_u_ff);
         se_tag_ff    <= sd_tag_ff;
         se_e_ff      <= e_in;
         out_color_ff <= se_tag_ff.byp ? se_tag_ff.new_color : mix_in;
         finished_ff  <= se_tag_ff.fin;
      end
   end

   assign rsp_if.valid     = sf_vld_ff;
   assign rsp_if.out_color = out_color_ff;
   assign rsp_if.finished  = finished_ff;

endmodule

// ----- dv/ecf_checker.sv -----
// Checker for the eased colour crossfade: watches pixel, result and duration channels,
// predicts each result and compares it. Depends on ecf_pkg and the channel interfaces.
`timescale 1ns / 1ps
module ecf_checker import ecf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ecf_req_if          req_if,
   ecf_rsp_if          rsp_if,
   ecf_csr_if          csr_if,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [ColorW-1:0] color;
      logic              finished;
   } pixel_result_type;

   logic [DurMsW-1:0] duration_ms;
   pixel_result_type  expected_pixels[$];

   // Cubic ease-in-out on a Q0.16 progress value
   function automatic logic [16:0] ease_progress(input logic [16:0] p);
      logic [63:0] u;
      logic [63:0] c;
      if (p < 17'd32768) begin
         u = 64'(p);
         c = (4 * u * u * u + 64'h8000_0000) >> 32;
         return c[16:0];
      end
      u = 64'(65536) - 64'(p);
      c = 65536 - ((4 * u * u * u + 64'h8000_0000) >> 32);
      if (c > 65535) c = 65535;
      return c[16:0];
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                              input logic [16:0] e);
      logic [63:0] v;
      v = 64'(a) * (65536 - e) + 64'(b) * e + 32768;
      return v[23:16];
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [ColorW-1:0] oldc,
         input logic [ColorW-1:0] newc, input logic [ElapsedW-1:0] el, input logic act);
      pixel_result_type r;
      logic [63:0] dur;
      logic [63:0] p;
      logic [16:0] e;
      dur = 64'(duration_ms) * 1000;
      r.color = newc;
      r.finished = 1'b0;
      if (act) begin
         if (64'(el) > dur) begin
            r.finished = 1'b1;
         end else if (dur != 0) begin
            p = (64'(el) << 16) / dur;
            if (p > 65535) p = 65535;
            e = ease_progress(p[16:0]);
            r.color = {mix_channel(oldc[23:16], newc[23:16], e),
                       mix_channel(oldc[15:8], newc[15:8], e),
                       mix_channel(oldc[7:0], newc[7:0], e)};
         end
      end
      return r;
   endfunction

   // Track duration writes, predict accepted words, compare results
   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (reset) begin
         duration_ms <= '0;
         expected_pixels.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result word with nothing expected: %h %b", $realtime,
                           rsp_if.out_color, rsp_if.finished);
               fail_count <= fail_count + 1;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (exp_px.color !== rsp_if.out_color || exp_px.finished !== rsp_if.finished)
               begin
                  if (fail_count < 10)
                     $display("%0t: mismatch: expected %h/%b actual %h/%b", $realtime,
                              exp_px.color, exp_px.finished, rsp_if.out_color,
                              rsp_if.finished);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            expected_pixels.push_back(predict_pixel(req_if.old_color, req_if.new_color,
                                                    req_if.elapsed_us, req_if.active));
         if (csr_if.valid && csr_if.ready)
            duration_ms <= csr_if.data;
         pending <= expected_pixels.size();
      end
   end

endmodule

// ----- dv/tb_eased_color_crossfade.sv -----
// Testbench top for the eased colour crossfade: clock, reset, pixel and duration stimulus
// and the verdict. Depends on ecf_pkg, the channel interfaces, the block and ecf_checker.
`timescale 1ns / 1ps
module tb_eased_color_crossfade import ecf_pkg::*;;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   quiet_phase;
   bit   sink_quiet;

   ecf_req_if req_if();
   ecf_rsp_if rsp_if();
   ecf_csr_if csr_if();

   eased_color_crossfade DUT (.clock(clock), .reset(reset), .req_if(req_if.sink),
                              .rsp_if(rsp_if.source), .csr_if(csr_if.sink));

   ecf_checker checker_i (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
                          .csr_if(csr_if), .fail_count(fail_count), .pending(pending));

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // Result side: stall at random, except in the quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= sink_quiet || ($urandom_range(99) >= 34);
   end

   // Offer one pixel word, idling at random first outside the quiet stretch, and hold it until taken
   task automatic send_pixel(input logic [ColorW-1:0] oldc, input logic [ColorW-1:0] newc,
                             input logic [ElapsedW-1:0] el, input logic act);
      while (!quiet_phase && $urandom_range(99) < 34) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.old_color  <= oldc;
      req_if.new_color  <= newc;
      req_if.elapsed_us <= el;
      req_if.active     <= act;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop the pixel valid, let the pipeline drain, then write the duration
   task automatic set_duration(input logic [DurMsW-1:0] ms);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= ms;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Elapsed time near the interesting points of the current duration
   function automatic logic [ElapsedW-1:0] pick_elapsed(input logic [DurMsW-1:0] ms);
      int unsigned d;
      d = ms * 1000;
      case ($urandom_range(5))
         0: return ElapsedW'($urandom_range(d));
         1: return ElapsedW'(d);
         2: return ElapsedW'(d + $urandom_range(3));
         3: return (d > 3) ? ElapsedW'(d - $urandom_range(3)) : '0;
         4: return ElapsedW'($urandom_range(d / 2 + 2, (d > 4) ? d / 2 - 2 : 0));
         default: return ElapsedW'($urandom());
      endcase
   endfunction

   initial begin
      logic [DurMsW-1:0] durations[6];
      durations = '{16'd0, 16'd65535, 16'd1, 16'd250, 16'd3, 16'd40000};
      reset = 1'b1;
      quiet_phase = 1'b0;
      sink_quiet = 1'b0;
      req_if.valid <= 1'b0;
      req_if.old_color <= '0;
      req_if.new_color <= '0;
      req_if.elapsed_us <= '0;
      req_if.active <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero duration at reset, then extremes under a 1 s and a 65535 ms duration
      send_pixel(24'h000000, 24'hFFFFFF, 27'd0, 1'b1);
      send_pixel(24'h123456, 24'hABCDEF, 27'd1, 1'b1);
      set_duration(16'd1000);
      send_pixel(24'hFFFFFF, 24'h000000, 27'd0, 1'b1);
      send_pixel(24'h000000, 24'hFFFFFF, 27'd1000000, 1'b1);
      send_pixel(24'h000000, 24'hFFFFFF, 27'd1000001, 1'b1);
      send_pixel(24'h000000, 24'hFFFFFF, 27'd500000, 1'b1);
      send_pixel(24'hFF00FF, 24'h00FF00, 27'd499999, 1'b1);
      send_pixel(24'h00FF00, 24'hFF00FF, 27'd250000, 1'b1);
      send_pixel(24'hFFFFFF, 24'h000000, 27'h7FF_FFFF, 1'b1);
      send_pixel(24'hA5A5A5, 24'h5A5A5A, 27'd750000, 1'b0);
      send_pixel(24'h808080, 24'h7F7F7F, 27'h555_5555, 1'b0);
      set_duration(16'd65535);
      send_pixel(24'h000000, 24'hFFFFFF, 27'd65535000, 1'b1);
      send_pixel(24'h000000, 24'hFFFFFF, 27'd65535001, 1'b1);
      send_pixel(24'hFFFFFF, 24'h000000, 27'd32767500, 1'b1);
      send_pixel(24'h010203, 24'hFEFDFC, 27'd1, 1'b1);

      // Random phases over several durations; the second runs with no idling and no result stalls
      foreach (durations[k]) begin
         set_duration(durations[k]);
         quiet_phase = (k == 1);
         sink_quiet = (k == 1);
         for (int n = 0; n < 230; n++)
            send_pixel(ColorW'($urandom()), ColorW'($urandom()),
                       pick_elapsed(durations[k]), $urandom_range(99) < 85);
         quiet_phase = 1'b0;
         sink_quiet = 1'b0;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- eased_color_crossfade.f -----
hw/rtl/ecf_pkg.sv
hw/rtl/ecf_if.sv
hw/rtl/ecf_div.sv
hw/rtl/eased_color_crossfade.sv
dv/ecf_checker.sv
dv/tb_eased_color_crossfade.sv
